@@ hw/rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;

  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic load;    // latch the input transfer
    logic commit;  // update the entries and load the result register
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/lkvc_ctrl.sv @@
// Sequencing controller: input acceptance, execute step and result hold.
`default_nettype none

module lkvc_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output lkvc_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   commit;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_stall_o   = (state_q == S_EXEC);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lkvc_dp.sv @@
// Datapath: key match array, recency ranks, value store and result register.
`default_nettype none

module lkvc_dp #(
  parameter int unsigned ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lkvc_pkg::cmd_t                cmd_i,
  input  wire                           cfg_we_i,
  input  wire  [lkvc_pkg::CAP_BITS-1:0] cfg_capacity_i,
  input  wire                           operation_i,
  input  wire  [KEY_BITS-1:0]           key_i,
  input  wire  [VALUE_BITS-1:0]         value_i,
  output logic                          found_o,
  output logic [VALUE_BITS-1:0]         read_value_o
);

  localparam int unsigned RW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > lkvc_pkg::CAP_BITS) ? CW : lkvc_pkg::CAP_BITS;

  logic                          op_q;
  logic [KEY_BITS-1:0]           key_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic [KEY_BITS-1:0]           keys_q  [ENTRIES];
  logic [VALUE_BITS-1:0]         vals_q  [ENTRIES];
  logic [RW-1:0]                 rank_q  [ENTRIES];
  logic [ENTRIES-1:0]            valid_q;
  logic [CW-1:0]                 occ_q;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_q;
  logic                          found_q;
  logic [VALUE_BITS-1:0]         rdval_q;

  logic [ENTRIES-1:0]    hit_vec;
  logic [ENTRIES-1:0]    victim_vec;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    ins_vec;
  logic [ENTRIES-1:0]    kept_vec;
  logic                  hit;
  logic                  is_put;
  logic                  do_insert;
  logic                  do_evict;
  logic [RW-1:0]         hit_rank;
  logic [RW-1:0]         last_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [CMPW-1:0]       cap_ext;
  logic [CMPW-1:0]       eff_cap;
  logic [CMPW-1:0]       occ_ext;

  assign is_put    = (op_q == lkvc_pkg::OP_PUT);
  assign last_rank = RW'(occ_q - CW'(1));
  assign cap_ext   = CMPW'(cap_q);
  assign occ_ext   = CMPW'(occ_q);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (keys_q[i] == key_q);
      victim_vec[i] = valid_q[i] && (rank_q[i] == last_rank);
      hit_rank      = hit_rank | (hit_vec[i] ? rank_q[i] : '0);
      hit_value     = hit_value | (hit_vec[i] ? vals_q[i] : '0);
    end
  end

  assign hit       = |hit_vec;
  assign do_insert = is_put && !hit;
  assign do_evict  = do_insert && (occ_ext >= eff_cap);
  assign free_vec  = ~valid_q | (do_evict ? victim_vec : '0);
  // lowest free slot, one-hot
  assign ins_vec   = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign kept_vec  = valid_q & ~(do_evict ? victim_vec : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.commit) begin
      found_q <= hit;
      rdval_q <= (hit && !is_put) ? hit_value : '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit && is_put && hit_vec[i]) begin
          vals_q[i] <= value_q;
        end
        if (do_insert && ins_vec[i]) begin
          keys_q[i] <= key_q;
          vals_q[i] <= value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= lkvc_pkg::CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_i;
      end
      if (cmd_i.commit) begin
        if (hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
              rank_q[i] <= '0;
            end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
              rank_q[i] <= rank_q[i] + RW'(1);
            end
          end
        end else if (do_insert) begin
          valid_q <= kept_vec | ins_vec;
          if (!do_evict) begin
            occ_q <= occ_q + CW'(1);
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (ins_vec[i]) begin
              rank_q[i] <= '0;
            end else if (kept_vec[i]) begin
              rank_q[i] <= rank_q[i] + RW'(1);
            end
          end
        end
      end
    end
  end

  assign found_o      = found_q;
  assign read_value_o = rdval_q;

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy count disagrees with valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= int'(ENTRIES))
    else $error("occupancy above entry count");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_occ_no_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> occ_q >= $past(occ_q))
    else $error("occupancy dropped on a transfer");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/lru_key_value_cache_unit.sv @@
// Top level of the fully associative LRU key-value cache.
//
//  channel  dir  handshake                signals
//  in       in   in_valid_i / in_stall_o  operation_i, key_i, value_i
//  out      out  out_valid_o / out_stall_i found_o, read_value_o
//  cfg      in   cfg_valid_i / cfg_ready_o capacity_in_use_i
//
// An operation first registers the input transfer, then does the parallel key match,
// rank update and result register load in the execute step.
// The result register frees the execute step; it holds until out_stall_i drops.
// Reset clears valid bits, ranks and count; capacity resets to 16.
// cfg_ready_o is always high.
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           operation_i,
  input  wire  [KEY_BITS-1:0]           key_i,
  input  wire  [VALUE_BITS-1:0]         value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          found_o,
  output logic [VALUE_BITS-1:0]         read_value_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [lkvc_pkg::CAP_BITS-1:0] capacity_in_use_i
);

  lkvc_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_capacity_i (capacity_in_use_i),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .found_o        (found_o),
    .read_value_o   (read_value_o)
  );

endmodule

`default_nettype wire

@@ sim/lru_key_value_cache_unit_tb.sv @@
// Self-checking testbench for the LRU key-value cache: directed and random gets and puts.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;

  localparam int unsigned SLOTS = lkvc_pkg::ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_OPS = 140;

  typedef logic [lkvc_pkg::KEY_BITS_DEF-1:0] key_t;
  typedef logic [lkvc_pkg::VALUE_BITS_DEF-1:0] val_t;
  typedef logic [lkvc_pkg::CAP_BITS-1:0] cap_t;

  typedef struct {
    logic found;
    val_t read_value;
  } lookup_reply_t;

  class cache_scoreboard;
    key_t key_mem[SLOTS];
    val_t value_mem[SLOTS];
    bit live[SLOTS];
    int unsigned age[SLOTS];
    int unsigned held;
    cap_t cap_reg;
    lookup_reply_t replies[$];
    int errors, checked, hits, evictions;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        age[i] = 0;
      end
      held = 0;
      cap_reg = lkvc_pkg::CAP_RESET;
    endfunction

    function void set_capacity(cap_t c);
      cap_reg = c;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Update the cache image for one accepted transfer and queue its reply.
    function void note_input(logic op, key_t key, val_t val);
      int s, victim, slot;
      int unsigned r, top, lim;
      lookup_reply_t rep;
      s = -1;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && key_mem[i] == key && s < 0) s = i;
      rep.found = (s >= 0);
      rep.read_value = '0;
      if (s >= 0) begin
        hits++;
        r = age[s];
        for (int i = 0; i < SLOTS; i++)
          if (live[i] && age[i] < r) age[i]++;
        age[s] = 0;
        if (op == lkvc_pkg::OP_PUT) value_mem[s] = val;
        else rep.read_value = value_mem[s];
      end else if (op == lkvc_pkg::OP_PUT) begin
        lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
        if (held >= lim) begin
          victim = -1;
          top = 0;
          for (int i = 0; i < SLOTS; i++)
            if (live[i] && (victim < 0 || age[i] >= top)) begin
              victim = i;
              top = age[i];
            end
          if (victim >= 0) begin
            live[victim] = 1'b0;
            held--;
            evictions++;
          end
        end
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!live[i] && slot < 0) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (live[i]) age[i]++;
          live[slot] = 1'b1;
          key_mem[slot] = key;
          value_mem[slot] = val;
          age[slot] = 0;
          held++;
        end
      end
      replies.push_back(rep);
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic found, val_t rd);
      lookup_reply_t exp_rep;
      if (replies.size() == 0) begin
        report($sformatf("unexpected result found=%0b read_value=%h", found, rd));
      end else begin
        exp_rep = replies.pop_front();
        checked++;
        if (found !== exp_rep.found)
          report($sformatf("result %0d found=%0b, want %0b", checked, found, exp_rep.found));
        if (rd !== exp_rep.read_value)
          report($sformatf("result %0d read_value=%h, want %h", checked, rd,
                           exp_rep.read_value));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic operation_i = lkvc_pkg::OP_GET;
  key_t key_i = '0;
  val_t value_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  cap_t capacity_in_use_i = lkvc_pkg::CAP_RESET;
  logic in_stall_o, out_valid_o, found_o, cfg_ready_o;
  val_t read_value_o;

  cache_scoreboard sb;
  int unsigned cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int stall_mode = 0;
  int stall_left = 0;
  key_t key_pool[40];
  int pool_size;
  int cap_plan[12] = '{16, 0, 1, 31, 2, 5, 17, 8, 3, 12, 16, 4};

  lru_key_value_cache_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .key_i(key_i),
    .value_i(value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o(found_o),
    .read_value_o(read_value_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .capacity_in_use_i(capacity_in_use_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_key_value_cache_unit: mismatch");
      $finish;
    end
  end

  // Receiver stall pattern: modes from never stalling to mostly stalling.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(found_o, read_value_o);

  task send_op(logic op, key_t key, val_t val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    key_i <= key;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, key, val);
    sent++;
  endtask

  // Hold the sender until every expected result is back, then let the block settle.
  task drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_capacity(cap_t c);
    drain();
    cfg_valid_i <= 1'b1;
    capacity_in_use_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin
    int lim;
    key_t k;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, hit, miss, update, fill and eviction
    send_op(lkvc_pkg::OP_GET, 16'h0000, 16'hFFFF);
    send_op(lkvc_pkg::OP_PUT, 16'h0000, 16'hFFFF);
    send_op(lkvc_pkg::OP_PUT, 16'hFFFF, 16'h0000);
    send_op(lkvc_pkg::OP_GET, 16'h0000, 16'h0000);
    send_op(lkvc_pkg::OP_GET, 16'hFFFF, 16'hFFFF);
    send_op(lkvc_pkg::OP_PUT, 16'h0000, 16'hA5C3);
    send_op(lkvc_pkg::OP_GET, 16'h0000, 16'h0000);
    send_op(lkvc_pkg::OP_GET, 16'h5555, 16'hAAAA);
    for (int i = 0; i < 14; i++)
      send_op(lkvc_pkg::OP_PUT, key_t'(16'h0100 + i), val_t'(16'h8000 + i));
    send_op(lkvc_pkg::OP_PUT, 16'h7777, 16'h1234);
    send_op(lkvc_pkg::OP_GET, 16'hFFFF, 16'h0000);
    // capacity dropped below the occupancy
    write_capacity(5'd2);
    send_op(lkvc_pkg::OP_PUT, 16'h2222, 16'h4321);
    send_op(lkvc_pkg::OP_GET, 16'h0000, 16'h0000);
    send_op(lkvc_pkg::OP_GET, 16'h2222, 16'h0000);

    foreach (cap_plan[p]) begin
      write_capacity(cap_t'(cap_plan[p]));
      lim = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > SLOTS) ? SLOTS : cap_plan[p]);
      pool_size = lim + $urandom_range(1, lim + 2);
      for (int i = 0; i < pool_size; i++) key_pool[i] = key_t'($urandom_range(0, 16'hFFFF));
      for (int n = 0; n < PHASE_OPS; n++) begin
        if ($urandom_range(0, 9) == 0) k = key_t'($urandom_range(0, 16'hFFFF));
        else k = key_pool[$urandom_range(0, pool_size - 1)];
        send_op($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, k,
                val_t'($urandom_range(0, 16'hFFFF)));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end of run");
    $display("covered %0d transfers under capacities 0 to 31, %0d results checked",
             sent, sb.checked);
    $display("%0d lookups hit, %0d entries evicted", sb.hits, sb.evictions);
    if (sb.errors == 0) begin
      $display("lru_key_value_cache_unit: match");
    end else begin
      $display("lru_key_value_cache_unit: mismatch");
    end
    $finish;
  end

endmodule
